### sv/tcce_pkg.sv
// Shared types and codes of the text console cell engine.
package tcce_pkg;

   typedef struct packed {
      logic [2:0] func;
      logic [6:0] pos_col;
      logic [4:0] pos_row;
      logic [7:0] char_code;
      logic [3:0] fill_colour;
      logic [6:0] area_width;
      logic [5:0] area_height;
   } req_type;

   typedef struct packed {
      logic [15:0] cell_word;
      logic [7:0]  cursor_col;
      logic [5:0]  cursor_row;
      logic        dropped_write;
      logic        did_scroll;
   } rsp_type;

   localparam logic [2:0] FUNC_SET_CURSOR = 3'd0;
   localparam logic [2:0] FUNC_PRINT      = 3'd1;
   localparam logic [2:0] FUNC_PUT        = 3'd2;
   localparam logic [2:0] FUNC_CLEAR      = 3'd3;
   localparam logic [2:0] FUNC_CLEAR_AREA = 3'd4;
   localparam logic [2:0] FUNC_READ       = 3'd5;

   localparam logic [7:0] CSR_TEXT_COLOUR = 8'd0;
   localparam logic [7:0] CSR_BACK_COLOUR = 8'd1;
   localparam logic [7:0] CSR_COLUMNS     = 8'd2;
   localparam logic [7:0] CSR_ROWS        = 8'd3;

   localparam logic [7:0] CH_NUL     = 8'd0;
   localparam logic [7:0] CH_TAB     = 8'd9;
   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_SPACE   = 8'd32;

endpackage

### sv/tcce_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2560
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/text_console_cell_engine.sv
// Top level of the text console cell engine: sequencer around the screen RAM.
//
// The block keeps a screen of 16-bit cells (back colour 15:12, text colour 11:8,
// character 7:0) in one RAM of MAX_ROWS x MAX_COLUMNS words and handles one
// request beat at a time; each beat yields exactly one response beat. Every
// cell access goes through the one RAM port pair and one shared address unit
// (row * MAX_COLUMNS + column), so timing follows the number of cells touched.
// Set cursor, a print of the terminating character, an empty clear area, an
// off-screen read and the unused codes go straight to completion; put and
// plain print write one cell, an on-screen read waits for the registered
// read data, a tab reduces the column by repeated subtraction of TAB_STOP,
// a clear walks every cell of the rectangle (rows x columns for the whole
// screen, area_height x area_width for an area, off-screen cells included),
// and a print that scrolls first copies columns x (rows - 1) cells up a row,
// each read and then written, then blanks the bottom row. The input
// stalls from the accepting edge until the response is loaded, and a stalled
// response holds the block in its last step. After reset a clearing pass
// zeroes all MAX_COLUMNS x MAX_ROWS words of the RAM before the
// first request is taken; configuration writes are taken at any time and
// should only be issued while the block is idle.
module text_console_cell_engine #(
   parameter int MAX_COLUMNS = 80,
   parameter int MAX_ROWS    = 32,
   parameter int TAB_STOP    = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tcce_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tcce_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_index,
   input  logic [7:0]       csr_data
);

   localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
   localparam int AW    = $clog2(CELLS);

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_SCR_RD, ST_SCR_WR, ST_SCR_ZERO, ST_PRINT,
      ST_TAB, ST_PUT, ST_CLEAR, ST_READ, ST_READ_WAIT, ST_DONE
   } state_type;

   state_type   state_ff;
   logic [AW-1:0] init_ff;

   // configuration
   logic [3:0] text_colour_ff, back_colour_ff;
   logic [6:0] columns_ff;
   logic [5:0] rows_ff;

   // architectural state
   logic [7:0]  cur_col_ff;
   logic [5:0]  cur_line_ff;
   logic [15:0] last_word_ff;

   // latched request and walk counters
   tcce_pkg::req_type item_ff;
   logic [7:0]  col_ff, c0_ff, c_end_ff, rem_ff;
   logic [6:0]  row_ff, r_end_ff;
   logic [15:0] space_ff, read_word_ff;
   logic        is_read_ff, dropped_ff, scrolled_ff;

   logic        rsp_valid_ff;
   tcce_pkg::rsp_type rsp_data_ff;

   // effective screen size, saturated to 1..MAX
   logic [7:0] cols_eff;
   logic [6:0] rows_eff;

   always_comb begin
      if (columns_ff == 7'd0)                 cols_eff = 8'd1;
      else if ({1'b0, columns_ff} > 8'(MAX_COLUMNS)) cols_eff = 8'(MAX_COLUMNS);
      else                                    cols_eff = {1'b0, columns_ff};
      if (rows_ff == 6'd0)                    rows_eff = 7'd1;
      else if ({1'b0, rows_ff} > 7'(MAX_ROWS)) rows_eff = 7'(MAX_ROWS);
      else                                    rows_eff = {1'b0, rows_ff};
   end

   // shared address unit
   logic [6:0]  row_sel;
   logic [7:0]  col_sel;
   logic [15:0] addr_full;
   logic [AW-1:0] addr;
   logic        on_screen;

   always_comb begin
      unique case (state_ff)
         ST_SCR_RD: begin
            row_sel = 7'(row_ff + 7'd1);
            col_sel = col_ff;
         end
         ST_PRINT: begin
            row_sel = {1'b0, cur_line_ff};
            col_sel = cur_col_ff;
         end
         ST_PUT, ST_READ: begin
            row_sel = {2'b00, item_ff.pos_row};
            col_sel = {1'b0, item_ff.pos_col};
         end
         default: begin
            row_sel = row_ff;
            col_sel = col_ff;
         end
      endcase
      addr_full = 16'(row_sel) * 16'(MAX_COLUMNS) + 16'(col_sel);
      addr      = (state_ff == ST_INIT) ? init_ff : addr_full[AW-1:0];
      on_screen = (col_sel < cols_eff) && (row_sel < rows_eff);
   end

   // RAM write side
   logic        wr_en;
   logic [15:0] wr_data;
   logic [15:0] pword;
   logic        print_cell;
   logic [15:0] rd_data;

   assign pword = {back_colour_ff, text_colour_ff, item_ff.char_code};
   assign print_cell = (item_ff.char_code != tcce_pkg::CH_NEWLINE) &&
                       (item_ff.char_code != tcce_pkg::CH_TAB);

   always_comb begin
      wr_en   = 1'b0;
      wr_data = 16'd0;
      unique case (state_ff)
         ST_INIT:     wr_en = 1'b1;
         ST_SCR_WR: begin
            wr_en   = 1'b1;
            wr_data = rd_data;
         end
         ST_SCR_ZERO: wr_en = 1'b1;
         ST_PRINT: begin
            wr_en   = print_cell && on_screen;
            wr_data = pword;
         end
         ST_PUT: begin
            wr_en   = on_screen;
            wr_data = pword;
         end
         ST_CLEAR: begin
            wr_en   = on_screen;
            wr_data = space_ff;
         end
         default: ;
      endcase
   end

   tcce_ram #(.WIDTH(16), .DEPTH(CELLS)) u_screen (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data (wr_data),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   logic [8:0] tab_sum;
   assign tab_sum = {1'b0, cur_col_ff} + 9'(TAB_STOP) - {1'b0, rem_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_INIT;
         init_ff        <= '0;
         text_colour_ff <= 4'd15;
         back_colour_ff <= 4'd0;
         columns_ff     <= 7'd80;
         rows_ff        <= 6'd25;
         cur_col_ff     <= 8'd0;
         cur_line_ff    <= 6'd0;
         last_word_ff   <= 16'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               tcce_pkg::CSR_TEXT_COLOUR: text_colour_ff <= csr_data[3:0];
               tcce_pkg::CSR_BACK_COLOUR: back_colour_ff <= csr_data[3:0];
               tcce_pkg::CSR_COLUMNS:     columns_ff     <= csr_data[6:0];
               tcce_pkg::CSR_ROWS:        rows_ff        <= csr_data[5:0];
               default: ;
            endcase
         end
         // drop the response once taken, unless the last step reloads it
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_INIT: begin
               // zero the whole RAM once after reset
               init_ff <= AW'(init_ff + 1'b1);
               if (init_ff == AW'(CELLS - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req_valid) begin
                  item_ff      <= req_data;
                  is_read_ff   <= (req_data.func == tcce_pkg::FUNC_READ);
                  dropped_ff   <= 1'b0;
                  read_word_ff <= 16'd0;
                  scrolled_ff  <= (req_data.func == tcce_pkg::FUNC_PRINT) &&
                                  (req_data.char_code != tcce_pkg::CH_NUL) &&
                                  ({1'b0, cur_line_ff} >= rows_eff);
                  space_ff     <= {req_data.fill_colour, text_colour_ff, tcce_pkg::CH_SPACE};
                  if (req_data.func == tcce_pkg::FUNC_CLEAR_AREA) begin
                     row_ff <= {2'b00, req_data.pos_row};
                     col_ff <= {1'b0, req_data.pos_col};
                     c0_ff  <= {1'b0, req_data.pos_col};
                  end else begin
                     row_ff <= '0;
                     col_ff <= '0;
                     c0_ff  <= '0;
                  end
                  unique case (req_data.func)
                     tcce_pkg::FUNC_SET_CURSOR: begin
                        cur_col_ff  <= {1'b0, req_data.pos_col};
                        cur_line_ff <= {1'b0, req_data.pos_row};
                        state_ff    <= ST_DONE;
                     end
                     tcce_pkg::FUNC_PRINT: begin
                        if (req_data.char_code == tcce_pkg::CH_NUL) begin
                           state_ff <= ST_DONE;
                        end else if ({1'b0, cur_line_ff} >= rows_eff) begin
                           if (rows_eff == 7'd1) state_ff <= ST_SCR_ZERO;
                           else                  state_ff <= ST_SCR_RD;
                        end else begin
                           state_ff <= ST_PRINT;
                        end
                     end
                     tcce_pkg::FUNC_PUT: state_ff <= ST_PUT;
                     tcce_pkg::FUNC_CLEAR: begin
                        c_end_ff <= cols_eff;
                        r_end_ff <= rows_eff;
                        state_ff <= ST_CLEAR;
                     end
                     tcce_pkg::FUNC_CLEAR_AREA: begin
                        c_end_ff <= {1'b0, req_data.pos_col} + {1'b0, req_data.area_width};
                        r_end_ff <= {2'b00, req_data.pos_row} + {1'b0, req_data.area_height};
                        if (req_data.area_width != 7'd0 && req_data.area_height != 6'd0) begin
                           state_ff <= ST_CLEAR;
                        end else begin
                           state_ff <= ST_DONE;
                        end
                     end
                     tcce_pkg::FUNC_READ: begin
                        if ({1'b0, req_data.pos_col} < cols_eff &&
                            {2'b00, req_data.pos_row} < rows_eff) begin
                           state_ff <= ST_READ;
                        end else begin
                           state_ff <= ST_DONE;
                        end
                     end
                     default: state_ff <= ST_DONE;
                  endcase
               end
            end
            ST_SCR_RD: state_ff <= ST_SCR_WR;
            ST_SCR_WR: begin
               // copy one cell up; advance along the row, then to the next row
               if (col_ff == 8'(cols_eff - 8'd1)) begin
                  col_ff <= '0;
                  row_ff <= 7'(row_ff + 7'd1);
                  if (7'(row_ff + 7'd1) == 7'(rows_eff - 7'd1)) state_ff <= ST_SCR_ZERO;
                  else                                          state_ff <= ST_SCR_RD;
               end else begin
                  col_ff   <= 8'(col_ff + 8'd1);
                  state_ff <= ST_SCR_RD;
               end
            end
            ST_SCR_ZERO: begin
               // blank the bottom row, then move the cursor up one line
               row_ff <= 7'(rows_eff - 7'd1);
               col_ff <= 8'(col_ff + 8'd1);
               if (col_ff == 8'(cols_eff - 8'd1)) begin
                  if (cur_line_ff != 6'd0) cur_line_ff <= 6'(cur_line_ff - 6'd1);
                  state_ff <= ST_PRINT;
               end
            end
            ST_PRINT: begin
               if (item_ff.char_code == tcce_pkg::CH_NEWLINE) begin
                  cur_col_ff <= 8'd0;
                  if (cur_line_ff < 6'd63) cur_line_ff <= 6'(cur_line_ff + 6'd1);
                  state_ff <= ST_DONE;
               end else if (item_ff.char_code == tcce_pkg::CH_TAB) begin
                  rem_ff   <= cur_col_ff;
                  state_ff <= ST_TAB;
               end else begin
                  if (on_screen) last_word_ff <= pword;
                  else           dropped_ff   <= 1'b1;
                  if (cur_col_ff != 8'd255) cur_col_ff <= 8'(cur_col_ff + 8'd1);
                  state_ff <= ST_DONE;
               end
            end
            ST_TAB: begin
               // reduce the column modulo the tab stop by repeated subtraction
               if (rem_ff >= 8'(TAB_STOP)) begin
                  rem_ff <= 8'(rem_ff - 8'(TAB_STOP));
               end else begin
                  cur_col_ff <= tab_sum[8] ? 8'd255 : tab_sum[7:0];
                  state_ff   <= ST_DONE;
               end
            end
            ST_PUT: begin
               if (on_screen) last_word_ff <= pword;
               else           dropped_ff   <= 1'b1;
               state_ff <= ST_DONE;
            end
            ST_CLEAR: begin
               if (on_screen) last_word_ff <= space_ff;
               else           dropped_ff   <= 1'b1;
               if (8'(col_ff + 8'd1) == c_end_ff) begin
                  col_ff <= c0_ff;
                  row_ff <= 7'(row_ff + 7'd1);
                  if (7'(row_ff + 7'd1) == r_end_ff) state_ff <= ST_DONE;
               end else begin
                  col_ff <= 8'(col_ff + 8'd1);
               end
            end
            ST_READ:      state_ff <= ST_READ_WAIT;
            ST_READ_WAIT: begin
               read_word_ff <= rd_data;
               state_ff     <= ST_DONE;
            end
            ST_DONE: begin
               // hold until the response register is free
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff              <= 1'b1;
                  rsp_data_ff.cell_word     <= is_read_ff ? read_word_ff : last_word_ff;
                  rsp_data_ff.cursor_col    <= cur_col_ff;
                  rsp_data_ff.cursor_row    <= cur_line_ff;
                  rsp_data_ff.dropped_write <= dropped_ff;
                  rsp_data_ff.did_scroll    <= scrolled_ff;
                  state_ff                  <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_DONE) |-> !wr_en)
      else $error("screen write while no item in work");

   a_scroll_flag: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCR_RD || state_ff == ST_SCR_WR || state_ff == ST_SCR_ZERO)
      |-> scrolled_ff)
      else $error("scroll walk without scroll flag");

   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (32'(addr) < CELLS))
      else $error("screen write address beyond store");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside completion");

endmodule
